// ----- hw/rtl/htls_pkg.sv -----
// ----------------------------------------------------------------------------
// htls_pkg
// Shared request and result types of the hex token line selector.
// ----------------------------------------------------------------------------
package htls_pkg;

    // One input request: a character byte or the end-of-input marker.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } htls_char_t;

    // One result: the signed token value and its digit count.
    typedef struct packed {
        logic [63:0] number_bits;
        logic [7:0]  digit_count;
    } htls_result_t;

endpackage

// ----- hw/rtl/hex_token_line_selector_top.sv -----
// ----------------------------------------------------------------------------
// hex_token_line_selector_top
// Scans a character stream, keeps the last two valid signed hex tokens of
// each line and emits the second-to-last one (or the only one) at line end.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------
//  char      in         char_valid / char_stall   char_item   (htls_char_t)
//  result    out        result_valid / result_stall result_item (htls_result_t)
//
//  An accepted request sits in the input register; once the result side is free the
//  scan logic (a digit shift, a mode change, a 64-bit negation) loads the result
//  register from it, so each result comes from the request that closes its line.
//  Requests are taken in every cycle while the result side drains.
//  Reset (rst_n low, asynchronous) clears the scan state and both valid flags.
//  A result held by result_stall raises char_stall once the input register is full.
//
module hex_token_line_selector_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  htls_pkg::htls_char_t   char_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output htls_pkg::htls_result_t result_item
);

    // Scan mode of the character stream. The zero code is never entered and
    // falls into the between-tokens arm.
    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd1,
        MODE_TOKEN   = 2'd2,
        MODE_BAD     = 2'd3
    } scan_mode_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] DIGITS_MAX = 8'd255;

    // Input register.
    logic                 in_valid_reg;
    htls_pkg::htls_char_t in_data_reg;

    // Scan state.
    scan_mode_t  mode_reg, mode_next;
    logic        tok_neg_reg, tok_neg_next;
    logic [63:0] tok_value_reg, tok_value_next;
    logic [7:0]  tok_digits_reg, tok_digits_next;
    logic [1:0]  kept_reg, kept_next;
    logic [63:0] new_value_reg, new_value_next;
    logic        new_neg_reg, new_neg_next;
    logic [7:0]  new_digits_reg, new_digits_next;
    logic [63:0] old_value_reg, old_value_next;
    logic        old_neg_reg, old_neg_next;
    logic [7:0]  old_digits_reg, old_digits_next;

    // Result register.
    logic                   result_valid_reg;
    htls_pkg::htls_result_t result_data_reg;

    logic        advance;
    logic        step;
    logic        char_accept;
    logic        is_end;
    logic        is_space;
    logic        is_sign;
    logic        dig_ok;
    logic [3:0]  dig_val;
    logic        line_end;
    logic        emit;
    logic [63:0] sel_value;
    logic        sel_neg;
    logic [7:0]  sel_digits;

    // Decodes one hex digit character; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // The pipeline moves whenever the result register is free or is taken.
    assign advance     = !result_valid_reg || !result_stall;
    assign step        = in_valid_reg && advance;
    assign char_stall  = in_valid_reg && !advance;
    assign char_accept = char_valid && !char_stall;

    always_comb
    begin
        logic [4:0] dec;
        dec      = hex_decode(in_data_reg.char_code);
        is_end   = in_data_reg.end_of_input || in_data_reg.char_code == CH_LF ||
                   in_data_reg.char_code == CH_CR;
        is_space = is_end || in_data_reg.char_code == CH_SPACE ||
                   in_data_reg.char_code == CH_TAB;
        dig_ok   = !in_data_reg.end_of_input && dec[4];
        dig_val  = dec[3:0];
        is_sign  = !in_data_reg.end_of_input && (in_data_reg.char_code == CH_PLUS ||
                   in_data_reg.char_code == CH_MINUS);
    end

    always_comb
    begin
        logic keep;
        keep            = 1'b0;
        line_end        = 1'b0;
        mode_next       = mode_reg;
        tok_neg_next    = tok_neg_reg;
        tok_value_next  = tok_value_reg;
        tok_digits_next = tok_digits_reg;
        kept_next       = kept_reg;
        new_value_next  = new_value_reg;
        new_neg_next    = new_neg_reg;
        new_digits_next = new_digits_reg;
        old_value_next  = old_value_reg;
        old_neg_next    = old_neg_reg;
        old_digits_next = old_digits_reg;
        sel_value       = new_value_reg;
        sel_neg         = new_neg_reg;
        sel_digits      = new_digits_reg;
        emit            = 1'b0;

        if (step) begin
            unique case (mode_reg)
                MODE_TOKEN:
                begin
                    if (dig_ok) begin
                        tok_value_next = {tok_value_reg[59:0], dig_val};
                        if (tok_digits_reg != DIGITS_MAX) begin
                            tok_digits_next = tok_digits_reg + 8'd1;
                        end
                    end else if (is_space) begin
                        // A lone sign has no digits and is not kept.
                        keep         = tok_digits_reg != 8'd0;
                        tok_neg_next = 1'b0;
                        mode_next    = MODE_BETWEEN;
                        line_end     = is_end;
                    end else begin
                        tok_neg_next = 1'b0;
                        mode_next    = MODE_BAD;
                    end
                end
                MODE_BAD:
                begin
                    if (is_space) begin
                        mode_next = MODE_BETWEEN;
                        line_end  = is_end;
                    end
                end
                default:
                begin
                    mode_next = MODE_BETWEEN;
                    if (is_sign) begin
                        tok_neg_next    = in_data_reg.char_code == CH_MINUS;
                        tok_value_next  = 64'd0;
                        tok_digits_next = 8'd0;
                        mode_next       = MODE_TOKEN;
                    end else if (dig_ok) begin
                        tok_neg_next    = 1'b0;
                        tok_value_next  = {60'd0, dig_val};
                        tok_digits_next = 8'd1;
                        mode_next       = MODE_TOKEN;
                    end else if (!is_space) begin
                        mode_next = MODE_BAD;
                    end else begin
                        line_end = is_end;
                    end
                end
            endcase

            if (keep) begin
                old_value_next  = new_value_reg;
                old_neg_next    = new_neg_reg;
                old_digits_next = new_digits_reg;
                new_value_next  = tok_value_reg;
                new_neg_next    = tok_neg_reg;
                new_digits_next = tok_digits_reg;
                if (kept_reg != 2'd2) begin
                    kept_next = kept_reg + 2'd1;
                end
            end

            // With two kept tokens the older one is reported.
            if (kept_next == 2'd1) begin
                sel_value  = new_value_next;
                sel_neg    = new_neg_next;
                sel_digits = new_digits_next;
            end else begin
                sel_value  = old_value_next;
                sel_neg    = old_neg_next;
                sel_digits = old_digits_next;
            end

            if (line_end) begin
                emit      = kept_next != 2'd0;
                kept_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_reg         <= MODE_BETWEEN;
            tok_neg_reg      <= 1'b0;
            tok_value_reg    <= 64'd0;
            tok_digits_reg   <= 8'd0;
            kept_reg         <= 2'd0;
            new_value_reg    <= 64'd0;
            new_neg_reg      <= 1'b0;
            new_digits_reg   <= 8'd0;
            old_value_reg    <= 64'd0;
            old_neg_reg      <= 1'b0;
            old_digits_reg   <= 8'd0;
        end else begin
            if (char_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                result_valid_reg <= emit;
            end
            mode_reg       <= mode_next;
            tok_neg_reg    <= tok_neg_next;
            tok_value_reg  <= tok_value_next;
            tok_digits_reg <= tok_digits_next;
            kept_reg       <= kept_next;
            new_value_reg  <= new_value_next;
            new_neg_reg    <= new_neg_next;
            new_digits_reg <= new_digits_next;
            old_value_reg  <= old_value_next;
            old_neg_reg    <= old_neg_next;
            old_digits_reg <= old_digits_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (char_accept) begin
            in_data_reg <= char_item;
        end
        if (emit) begin
            result_data_reg.number_bits <= sel_neg ? (64'd0 - sel_value) : sel_value;
            result_data_reg.digit_count <= sel_digits;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_data_reg;

`ifndef SYNTHESIS
    // A reported token always has at least one digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_data_reg.digit_count != 8'd0)
        else $error("result with zero digit count");

    // The kept-token count saturates at two.
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg != 2'd3)
        else $error("kept token count overflow");

    // The input side only stalls while it holds a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> in_valid_reg)
        else $error("stall without a held request");

    // A request that ends no reported line leaves the result register empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !emit) |=> !result_valid_reg)
        else $error("result appeared without a line end");

    // Reporting a line empties the kept tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> kept_reg == 2'd0)
        else $error("kept tokens survive a line end");
`endif

endmodule
